// ----- rtl/tlbbf_pkg.sv -----
// Shared types, widths and codes for the direct-mapped TLB with block fill.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package tlbbf_pkg;

   localparam int TLB_ENTRIES = 16;
   localparam int CACHE_LINES = 64;
   localparam int PAGES       = 256;
   localparam int BLOCK_BYTES = 4;
   localparam int MEM_BYTES   = PAGES * BLOCK_BYTES;

   localparam int CMD_W    = 2;
   localparam int VADDR_W  = 10;
   localparam int PTPAGE_W = 8;
   localparam int FRAME_W  = 4;
   localparam int BYTE_W   = 8;

   localparam int OFF_W    = $clog2(BLOCK_BYTES);
   localparam int PAGE_W   = $clog2(PAGES);
   localparam int TLB_IW   = $clog2(TLB_ENTRIES);
   localparam int CACHE_AW = $clog2(CACHE_LINES);
   localparam int MEM_AW   = $clog2(MEM_BYTES);
   localparam int SLOT_W   = FRAME_W + OFF_W + 1;

   typedef logic [CMD_W-1:0] op_type;

   localparam op_type OP_READ   = 2'd0;
   localparam op_type OP_PT_WR  = 2'd1;
   localparam op_type OP_MEM_WR = 2'd2;
   localparam op_type OP_NONE   = 2'd3;

   // Decoded item as it sits in the queue between front and back.
   typedef struct packed {
      op_type              op;
      logic [PAGE_W-1:0]   page;
      logic [OFF_W-1:0]    off;
      logic [MEM_AW-1:0]   mem_addr;
      logic [PAGE_W-1:0]   pt_page;
      logic                pt_valid;
      logic [FRAME_W-1:0]  pt_frame;
      logic [BYTE_W-1:0]   wr_byte;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } pt_entry_type;

   // Cache slot of byte i of a frame's block, wrapped to the cache size.
   function automatic logic [CACHE_AW-1:0] cache_slot(input logic [FRAME_W-1:0] frame,
                                                      input logic [OFF_W-1:0] i);
      logic [SLOT_W-1:0] sum;
      sum = (SLOT_W'(frame) << OFF_W) + SLOT_W'(i);
      return sum[CACHE_AW-1:0];
   endfunction

   // Backing memory address of byte i of a page.
   function automatic logic [MEM_AW-1:0] mem_addr(input logic [PAGE_W-1:0] page,
                                                  input logic [OFF_W-1:0] i);
      logic [PAGE_W+OFF_W-1:0] a;
      a = {page, i};
      return a[MEM_AW-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/tlbbf_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on tlbbf_pkg for field widths.
`default_nettype none

interface tlbbf_req_if import tlbbf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [VADDR_W-1:0]  vaddr;
   logic [PTPAGE_W-1:0] pt_page;
   logic                pt_valid;
   logic [FRAME_W-1:0]  pt_frame;
   logic [BYTE_W-1:0]   wr_byte;

   modport source (output valid, command, vaddr, pt_page, pt_valid, pt_frame, wr_byte,
                   input ready);
   modport sink (input valid, command, vaddr, pt_page, pt_valid, pt_frame, wr_byte,
                 output ready);
endinterface

interface tlbbf_rsp_if import tlbbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rd_byte;
   logic              tlb_hit;
   logic              page_fault;

   modport source (output valid, rd_byte, tlb_hit, page_fault, input ready);
   modport sink (input valid, rd_byte, tlb_hit, page_fault, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlbbf_front.sv -----
// Front end: accepts request beats, decodes them and pushes them into the queue.
// Depends on tlbbf_pkg and tlbbf_req_if.
`default_nettype none

module tlbbf_front import tlbbf_pkg::*; (
   tlbbf_req_if.sink    req,
   input  logic         clearing,
   input  q_status_type q_stat,
   output logic         push,
   output entry_type    push_data
);

   assign req.ready = !clearing && !q_stat.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      unique case (req.command)
         OP_READ:   push_data.op = OP_READ;
         OP_PT_WR:  push_data.op = OP_PT_WR;
         OP_MEM_WR: push_data.op = OP_MEM_WR;
         default:   push_data.op = OP_NONE;
      endcase
      push_data.page     = req.vaddr[OFF_W +: PAGE_W];
      push_data.off      = req.vaddr[OFF_W-1:0];
      push_data.mem_addr = req.vaddr[MEM_AW-1:0];
      push_data.pt_page  = req.pt_page[PAGE_W-1:0];
      push_data.pt_valid = req.pt_valid;
      push_data.pt_frame = req.pt_frame;
      push_data.wr_byte  = req.wr_byte;
   end

endmodule

`default_nettype wire

// ----- rtl/tlbbf_queue.sv -----
// Small FIFO of decoded items between the front end and the back end.
// Depends on tlbbf_pkg for the entry and status types.
`default_nettype none

module tlbbf_queue import tlbbf_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_data,
   input  logic         pop,
   output entry_type    head,
   output q_status_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tlbbf_back.sv -----
// Back end: TLB, page table, backing memory and block cache, plus the sequencer
// that runs lookups, page walks and block fills. Depends on tlbbf_pkg, tlbbf_rsp_if.
`default_nettype none

module tlbbf_back import tlbbf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_stat,
   input  entry_type    q_head,
   output logic         q_pop,
   output logic         clearing,
   tlbbf_rsp_if.source  rsp
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HIT   = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_COPY  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MEM_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [OFF_W-1:0]    cnt_ff, cnt_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [TLB_IW-1:0]   ti_ff, ti_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [BYTE_W-1:0]   cap_ff, cap_in;

   logic [TLB_ENTRIES-1:0] tlb_valid_ff;
   logic [PAGE_W-1:0]      tlb_page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0]     tlb_frame_ff [TLB_ENTRIES];
   logic                   tlb_we;

   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_fault_ff, rsp_fault_in;
   logic                rsp_load;

   logic [BYTE_W-1:0]   backing_mem [MEM_BYTES];
   logic                mem_we;
   logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
   logic [BYTE_W-1:0]   mem_wdata, mem_rdata_ff;

   pt_entry_type        pt_mem [PAGES];
   logic                pt_we;
   logic [PAGE_W-1:0]   pt_waddr, pt_raddr;
   pt_entry_type        pt_wdata, pt_rdata_ff;

   logic [BYTE_W-1:0]   cache_mem [CACHE_LINES];
   logic                cache_we;
   logic [CACHE_AW-1:0] cache_waddr, cache_raddr;
   logic [BYTE_W-1:0]   cache_wdata, cache_rdata_ff;

   logic [TLB_IW-1:0]   head_ti;
   logic                head_hit;
   logic                out_free;
   logic [BYTE_W-1:0]   copy_byte;

   assign head_ti  = q_head.page[TLB_IW-1:0];
   assign head_hit = tlb_valid_ff[head_ti] && (tlb_page_ff[head_ti] == q_head.page);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign clearing = (state_ff == ST_CLEAR);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.rd_byte    = rsp_byte_ff;
   assign rsp.tlb_hit    = rsp_hit_ff;
   assign rsp.page_fault = rsp_fault_ff;

   // The byte wanted by the read is the last one copied into its slot.
   assign copy_byte = (cache_slot(frame_ff, cnt_ff) == cache_slot(frame_ff, off_ff)) ?
                      mem_rdata_ff : cap_ff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cnt_in       = cnt_ff;
      page_in      = page_ff;
      off_in       = off_ff;
      ti_in        = ti_ff;
      frame_in     = frame_ff;
      cap_in       = cap_ff;
      tlb_we       = 1'b0;
      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      rsp_byte_in  = '0;
      rsp_hit_in   = 1'b0;
      rsp_fault_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = q_head.mem_addr;
      mem_wdata    = q_head.wr_byte;
      mem_raddr    = mem_addr(page_ff, OFF_W'(cnt_ff + 1'b1));
      pt_we        = 1'b0;
      pt_waddr     = q_head.pt_page;
      pt_wdata     = '{valid: q_head.pt_valid, frame: q_head.pt_frame};
      pt_raddr     = q_head.page;
      cache_we     = 1'b0;
      cache_waddr  = cache_slot(frame_ff, cnt_ff);
      cache_wdata  = mem_rdata_ff;
      cache_raddr  = cache_slot(tlb_frame_ff[head_ti], q_head.off);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero every store, one address a cycle; the smaller ones wrap.
            mem_we      = 1'b1;
            mem_waddr   = clr_cnt_ff;
            mem_wdata   = '0;
            pt_we       = 1'b1;
            pt_waddr    = clr_cnt_ff[PAGE_W-1:0];
            pt_wdata    = '0;
            cache_we    = 1'b1;
            cache_waddr = clr_cnt_ff[CACHE_AW-1:0];
            cache_wdata = '0;
            clr_cnt_in  = MEM_AW'(clr_cnt_ff + 1'b1);
            if (clr_cnt_ff == MEM_AW'(MEM_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_stat.empty && out_free) begin
               q_pop = 1'b1;
               unique case (q_head.op)
                  OP_READ: begin
                     page_in = q_head.page;
                     off_in  = q_head.off;
                     ti_in   = head_ti;
                     state_in = head_hit ? ST_HIT : ST_WALK;
                  end
                  OP_PT_WR: begin
                     pt_we    = 1'b1;
                     rsp_load = 1'b1;
                  end
                  OP_MEM_WR: begin
                     mem_we   = 1'b1;
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_HIT: begin
            rsp_load    = 1'b1;
            rsp_byte_in = cache_rdata_ff;
            rsp_hit_in  = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_WALK: begin
            if (!pt_rdata_ff.valid) begin
               rsp_load     = 1'b1;
               rsp_fault_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               tlb_we    = 1'b1;
               frame_in  = pt_rdata_ff.frame;
               cnt_in    = '0;
               mem_raddr = mem_addr(page_ff, '0);
               state_in  = ST_COPY;
            end
         end
         ST_COPY: begin
            cache_we = 1'b1;
            cap_in   = copy_byte;
            if (cnt_ff == OFF_W'(BLOCK_BYTES - 1)) begin
               rsp_load    = 1'b1;
               rsp_byte_in = copy_byte;
               state_in    = ST_IDLE;
            end else begin
               cnt_in = OFF_W'(cnt_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         tlb_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         if (tlb_we) begin
            tlb_valid_ff[ti_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      page_ff  <= page_in;
      off_ff   <= off_in;
      ti_ff    <= ti_in;
      frame_ff <= frame_in;
      cap_ff   <= cap_in;
      if (tlb_we) begin
         tlb_page_ff[ti_ff]  <= page_ff;
         tlb_frame_ff[ti_ff] <= pt_rdata_ff.frame;
      end
      if (rsp_load) begin
         rsp_byte_ff  <= rsp_byte_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         backing_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= backing_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
      pt_rdata_ff <= pt_mem[pt_raddr];
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      cache_rdata_ff <= cache_mem[cache_raddr];
   end

endmodule

`default_nettype wire

// ----- rtl/direct_mapped_tlb_with_block_fill_core.sv -----
// Direct-mapped TLB with page table walk and cache block fill.
// Channels: req (valid/ready) carries a command: read byte, write page table
// entry or write backing memory byte. rsp (valid/ready) returns one beat per
// command: rd_byte, tlb_hit, page_fault; writes answer with all zero.
// Path: the front pushes the decoded command into the queue; the back end
// pops it in ST_IDLE and answers a write there, a hit via ST_HIT, a miss via
// ST_WALK (page fault) or ST_WALK and then ST_COPY, which fills the block.
// Throughput: one write per cycle while the output register is free; a read
// holds the sequencer until it answers; it owns the single read port of each memory.
// Reset: synchronous, active high. After reset the back end sweeps the backing
// memory, page table and cache to zero, one address a cycle; req.ready
// stays low until the sweep is done.
// Stall: a queue of QUEUE_DEPTH decoded commands sits between the front and
// back ends; a pending response waits in the output register while the front
// keeps taking requests until the queue fills.
`default_nettype none

module direct_mapped_tlb_with_block_fill_core import tlbbf_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   tlbbf_req_if.sink   req,
   tlbbf_rsp_if.source rsp
);

   logic         push;
   logic         pop;
   logic         clearing;
   entry_type    push_data;
   entry_type    head;
   q_status_type q_stat;

   tlbbf_front u_front (
      .req       (req),
      .clearing  (clearing),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   tlbbf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   tlbbf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .q_head   (head),
      .q_pop    (pop),
      .clearing (clearing),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// ----- rtl/tlbbf_checker.sv -----
// Port-level checks for the TLB block, bound to the top level.
// Depends on tlbbf_pkg for the byte width.
`default_nettype none

module tlbbf_checker import tlbbf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_rd_byte,
   input logic              rsp_tlb_hit,
   input logic              rsp_page_fault
);

   // A fault is reported only after a TLB miss.
   a_hit_excl_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("tlb_hit and page_fault both set");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_fault) |-> (rsp_rd_byte == '0))
      else $error("page fault with nonzero data");

   // The clearing sweep holds off requests right after reset.
   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing sweep");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rd_byte)))
      else $error("stalled response dropped or changed");

endmodule

bind direct_mapped_tlb_with_block_fill_core tlbbf_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_rd_byte    (rsp.rd_byte),
   .rsp_tlb_hit    (rsp.tlb_hit),
   .rsp_page_fault (rsp.page_fault)
);

`default_nettype wire
